// File: hw/rtl/bst_pkg.sv
// Shared types, constants and character-class helpers for the byte stream tokenizer.
// No dependencies; imported by bst_tok_fifo and byte_stream_tokenizer.
`default_nettype none

package bst_pkg;

    localparam int COUNTER_BITS_DEF = 20;
    localparam int OUT_W            = 20;
    localparam int KIND_W           = 6;
    localparam int KW_N             = 11;
    localparam int OP_N             = 6;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_AW          = 2;
    localparam int FIFO_CW          = 3;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WORD = 2'd1;
    localparam logic [1:0] MODE_HELD = 2'd2;

    localparam int F_DIGITS  = 0;
    localparam int F_ALNUM   = 1;
    localparam int F_FLOATOK = 2;
    localparam int F_DOT     = 3;
    localparam int F_HASDIG  = 4;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_IDENT   = 6'd0;
    localparam kind_t KIND_INT     = 6'd9;
    localparam kind_t KIND_FLOAT   = 6'd10;
    localparam kind_t KIND_STAR    = 6'd16;
    localparam kind_t KIND_ARROW   = 6'd26;
    localparam kind_t KIND_LPAREN  = 6'd27;
    localparam kind_t KIND_RPAREN  = 6'd28;
    localparam kind_t KIND_LBRACE  = 6'd29;
    localparam kind_t KIND_RBRACE  = 6'd30;
    localparam kind_t KIND_COMMA   = 6'd31;
    localparam kind_t KIND_COLON   = 6'd32;
    localparam kind_t KIND_SEMI    = 6'd33;
    localparam kind_t KIND_UNKNOWN = 6'd34;
    localparam kind_t KIND_LBRACK  = 6'd35;
    localparam kind_t KIND_RBRACK  = 6'd36;

    localparam logic [7:0] KW_TEXT [KW_N][8] = '{
        '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "a", "n", "g", "e", 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"t", "e", "n", "s", "o", "r", 8'h00, 8'h00},
        '{"i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_N] = '{
        3'd4, 3'd5, 3'd3, 3'd2, 3'd4, 3'd6, 3'd6, 3'd2, 3'd2, 3'd2, 3'd3
    };
    localparam kind_t KW_KIND [KW_N] = '{
        6'd1, 6'd4, 6'd2, 6'd5, 6'd6, 6'd7, 6'd8, 6'd3, 6'd24, 6'd24, 6'd23
    };

    localparam kind_t OP_SINGLE [OP_N] = '{6'd15, 6'd14, 6'd11, 6'd19, 6'd21, 6'd25};
    localparam kind_t OP_EQUAL  [OP_N] = '{6'd13, 6'd12, 6'd17, 6'd20, 6'd22, 6'd18};

    typedef struct packed {
        kind_t            kind;
        logic [OUT_W-1:0] line;
        logic [OUT_W-1:0] start;
        logic [OUT_W-1:0] length;
        logic             last;
    } token_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return b inside {"(", ")", "[", "]", "{", "}", ",", ":", "*", ";"};
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] b);
        kind_t k;
        case (b)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "[":     k = KIND_LBRACK;
            "]":     k = KIND_RBRACK;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ",":     k = KIND_COMMA;
            ":":     k = KIND_COLON;
            "*":     k = KIND_STAR;
            ";":     k = KIND_SEMI;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic is_op(input logic [7:0] b);
        return b inside {"-", "+", "=", "<", ">", "!"};
    endfunction

    function automatic logic [2:0] op_index(input logic [7:0] b);
        logic [2:0] i;
        case (b)
            "-":     i = 3'd0;
            "+":     i = 3'd1;
            "=":     i = 3'd2;
            "<":     i = 3'd3;
            ">":     i = 3'd4;
            "!":     i = 3'd5;
            default: i = 3'd0;
        endcase
        return i;
    endfunction

    function automatic logic [2:0] op_mod6(input logic [2:0] h);
        return (h >= 3'd6) ? (h - 3'd6) : h;
    endfunction

    function automatic kind_t word_class(input logic [KW_N-1:0] hit, input logic [4:0] flags);
        kind_t k;
        if (flags[F_DIGITS])
            k = KIND_INT;
        else if (flags[F_FLOATOK] && flags[F_HASDIG])
            k = KIND_FLOAT;
        else if (flags[F_ALNUM])
            k = KIND_IDENT;
        else
            k = KIND_UNKNOWN;
        for (int i = KW_N - 1; i >= 0; i--)
        begin
            if (hit[i])
                k = KW_KIND[i];
        end
        return k;
    endfunction

    function automatic token_t make_token(input kind_t kind, input logic [OUT_W-1:0] line,
                                          input logic [OUT_W-1:0] start,
                                          input logic [OUT_W-1:0] length);
        token_t t;
        t.kind   = kind;
        t.line   = line;
        t.start  = start;
        t.length = length;
        t.last   = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/byte_stream_tokenizer.sv
// Byte stream tokenizer top level: input word register, scan logic, token queue.
// A word is captured in the input word register; the scan logic writes its tokens
// into the token queue, whose head drives the output. Throughput: one word per cycle
// while the four-entry token queue holds two tokens or fewer; a word can yield up to
// two tokens. Reset (rst_n low, asynchronous) clears counters, scan state and the
// queue. Depends on bst_pkg and bst_tok_fifo.
`default_nettype none

module byte_stream_tokenizer
    import bst_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         byte_value,
    input  wire logic               end_of_text,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [KIND_W-1:0]       token_kind,
    output logic [OUT_W-1:0]        token_line,
    output logic [OUT_W-1:0]        token_start,
    output logic [OUT_W-1:0]        token_length,
    output logic                    run_last
);

    localparam logic [COUNTER_BITS-1:0] CMAX = {COUNTER_BITS{1'b1}};

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] x);
        return (x == CMAX) ? x : COUNTER_BITS'(x + 1'b1);
    endfunction

    logic                    valid_reg;
    logic [7:0]              byte_reg;
    logic                    last_reg;

    logic [COUNTER_BITS-1:0] line_reg, line_next;
    logic [COUNTER_BITS-1:0] pos_reg, pos_next;
    logic [COUNTER_BITS-1:0] begin_reg, begin_next;
    logic [COUNTER_BITS-1:0] wlen_reg, wlen_next;
    logic [1:0]              mode_reg, mode_next;
    logic [2:0]              held_reg, held_next;
    logic [KW_N-1:0]         cand_reg, cand_next;
    logic [4:0]              flags_reg, flags_next;

    logic                    fire;
    logic [FIFO_CW-1:0]      fill;
    token_t                  head;
    logic                    head_valid;
    token_t                  tok [2];
    logic [1:0]              ecnt;
    logic [1:0]              push_cnt;

    logic                    nz, sp, pu, op, delim, held_pair;
    logic                    take_idle, fresh, cont, add, clear;
    logic [2:0]              h;
    logic [COUNTER_BITS-1:0] base_len, new_len, cls_len;
    logic [KW_N-1:0]         base_cand, new_cand, cls_cand, hit;
    logic [4:0]              base_flags, new_flags, cls_flags;
    kind_t                   word_kind;

    assign fire     = valid_reg && (fill <= FIFO_CW'(FIFO_DEPTH - 2));
    assign in_stall = valid_reg && !fire;
    assign push_cnt = fire ? ecnt : 2'd0;

    always_comb
    begin
        nz        = (byte_reg != 8'h00);
        sp        = is_space(byte_reg);
        pu        = is_punct(byte_reg);
        op        = is_op(byte_reg);
        delim     = sp || pu || op;
        h         = op_mod6(held_reg);
        held_pair = (mode_reg == MODE_HELD) &&
                    (((h == 3'd0) && (byte_reg == ">")) || (byte_reg == "="));
        take_idle = nz && !held_pair && !((mode_reg == MODE_WORD) && !delim);
        fresh     = take_idle && !delim;
        cont      = nz && (mode_reg == MODE_WORD) && !delim;
        add       = fresh || cont;

        base_len   = fresh ? '0 : wlen_reg;
        base_cand  = fresh ? '1 : cand_reg;
        base_flags = fresh ? 5'b00111 : flags_reg;

        for (int k = 0; k < KW_N; k++)
        begin
            new_cand[k] = base_cand[k] && (base_len < COUNTER_BITS'(KW_LEN[k])) &&
                          (KW_TEXT[k][base_len[2:0]] == byte_reg);
        end

        new_flags = base_flags;
        if (!is_digit(byte_reg))
            new_flags[F_DIGITS] = 1'b0;
        else
            new_flags[F_HASDIG] = 1'b1;
        if (!is_alnum(byte_reg))
            new_flags[F_ALNUM] = 1'b0;
        if (byte_reg == ".")
        begin
            if (new_flags[F_DOT])
                new_flags[F_FLOATOK] = 1'b0;
            new_flags[F_DOT] = 1'b1;
        end
        else if (!is_digit(byte_reg))
        begin
            new_flags[F_FLOATOK] = 1'b0;
        end
        new_len = sat_inc(base_len);

        cls_len   = add ? new_len : wlen_reg;
        cls_cand  = add ? new_cand : cand_reg;
        cls_flags = add ? new_flags : flags_reg;
        for (int k = 0; k < KW_N; k++)
        begin
            hit[k] = cls_cand[k] && (cls_len == COUNTER_BITS'(KW_LEN[k]));
        end
        word_kind = word_class(hit, cls_flags);
    end

    always_comb
    begin
        line_next  = line_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        wlen_next  = wlen_reg;
        mode_next  = mode_reg;
        held_next  = held_reg;
        cand_next  = cand_reg;
        flags_next = flags_reg;
        tok[0]     = '0;
        tok[1]     = '0;
        ecnt       = 2'd0;
        clear      = 1'b0;

        if (!nz)
        begin
            if (mode_reg == MODE_WORD)
            begin
                tok[ecnt[0]] = make_token(word_kind, OUT_W'(line_reg), OUT_W'(begin_reg),
                                          OUT_W'(wlen_reg));
                ecnt = ecnt + 2'd1;
            end
            else if (mode_reg == MODE_HELD)
            begin
                tok[ecnt[0]] = make_token(OP_SINGLE[h], OUT_W'(line_reg), OUT_W'(begin_reg),
                                          OUT_W'(1));
                ecnt = ecnt + 2'd1;
            end
            clear = 1'b1;
        end
        else
        begin
            if (mode_reg == MODE_HELD)
            begin
                if (held_pair)
                    tok[ecnt[0]] = make_token(((h == 3'd0) && (byte_reg == ">")) ?
                                              KIND_ARROW : OP_EQUAL[h],
                                              OUT_W'(line_reg), OUT_W'(begin_reg), OUT_W'(2));
                else
                    tok[ecnt[0]] = make_token(OP_SINGLE[h], OUT_W'(line_reg),
                                              OUT_W'(begin_reg), OUT_W'(1));
                ecnt      = ecnt + 2'd1;
                mode_next = MODE_IDLE;
            end
            else if ((mode_reg == MODE_WORD) && delim)
            begin
                tok[ecnt[0]] = make_token(word_kind, OUT_W'(line_reg), OUT_W'(begin_reg),
                                          OUT_W'(wlen_reg));
                ecnt      = ecnt + 2'd1;
                mode_next = MODE_IDLE;
            end

            if (take_idle)
            begin
                if (sp)
                begin
                    if (byte_reg == 8'h0a)
                        line_next = sat_inc(line_reg);
                end
                else if (pu)
                begin
                    tok[ecnt[0]] = make_token(punct_kind(byte_reg), OUT_W'(line_reg),
                                              OUT_W'(pos_reg), OUT_W'(1));
                    ecnt = ecnt + 2'd1;
                end
                else if (op)
                begin
                    held_next  = op_index(byte_reg);
                    begin_next = pos_reg;
                    mode_next  = MODE_HELD;
                end
                else
                begin
                    begin_next = pos_reg;
                    mode_next  = MODE_WORD;
                end
            end

            if (add)
            begin
                wlen_next  = new_len;
                cand_next  = new_cand;
                flags_next = new_flags;
            end
            pos_next = sat_inc(pos_reg);

            if (last_reg)
            begin
                if (mode_next == MODE_WORD)
                begin
                    tok[ecnt[0]] = make_token(word_kind, OUT_W'(line_reg), OUT_W'(begin_next),
                                              OUT_W'(wlen_next));
                    ecnt = ecnt + 2'd1;
                end
                else if (mode_next == MODE_HELD)
                begin
                    tok[ecnt[0]] = make_token(OP_SINGLE[op_mod6(held_next)], OUT_W'(line_reg),
                                              OUT_W'(begin_next), OUT_W'(1));
                    ecnt = ecnt + 2'd1;
                end
                clear = 1'b1;
            end
        end

        if (ecnt == 2'd1)
            tok[0].last = 1'b1;
        else if (ecnt == 2'd2)
            tok[1].last = 1'b1;

        if (clear)
        begin
            line_next  = '0;
            pos_next   = '0;
            begin_next = '0;
            wlen_next  = '0;
            mode_next  = MODE_IDLE;
            held_next  = '0;
            cand_next  = '0;
            flags_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= byte_value;
            last_reg <= end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            line_reg  <= '0;
            pos_reg   <= '0;
            begin_reg <= '0;
            wlen_reg  <= '0;
            mode_reg  <= MODE_IDLE;
            held_reg  <= '0;
            cand_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            if (!in_stall)
                valid_reg <= in_valid;
            if (fire)
            begin
                line_reg  <= line_next;
                pos_reg   <= pos_next;
                begin_reg <= begin_next;
                wlen_reg  <= wlen_next;
                mode_reg  <= mode_next;
                held_reg  <= held_next;
                cand_reg  <= cand_next;
                flags_reg <= flags_next;
            end
        end
    end

    bst_tok_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push0      (tok[0]),
        .push1      (tok[1]),
        .pop        (!out_stall),
        .head       (head),
        .head_valid (head_valid),
        .fill       (fill)
    );

    assign out_valid    = head_valid;
    assign token_kind   = head.kind;
    assign token_line   = head.line;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign run_last     = head.last;

endmodule

`default_nettype wire

// File: hw/rtl/bst_tok_fifo.sv
// Output token queue: takes up to two tokens a cycle, gives one a cycle while pop is high.
// Depends on bst_pkg for token_t and queue sizing.
`default_nettype none

module bst_tok_fifo
    import bst_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [1:0]         push_cnt,
    input  wire token_t             push0,
    input  wire token_t             push1,
    input  wire logic               pop,
    output token_t                  head,
    output logic                    head_valid,
    output logic [FIFO_CW-1:0]      fill
);

    token_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 pop_ok;

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign fill       = count_reg;
    assign pop_ok     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = FIFO_AW'(wr_ptr_reg + FIFO_AW'(push_cnt));
        rd_ptr_next = pop_ok ? FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = FIFO_CW'(count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop_ok));
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem[FIFO_AW'(wr_ptr_reg + 1'b1)] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_byte_stream_tokenizer.sv
`timescale 1ns / 100ps
// Self-checking bench for byte_stream_tokenizer: a queue-fed byte driver, a stalling token
// sink and a monitor that checks each token against an in-bench tokenizer model.
// Depends on bst_pkg and the tokenizer RTL only.

module tb_byte_stream_tokenizer;
    import bst_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CNT_W        = COUNTER_BITS_DEF;
    localparam int MAX_PER_WORD = 2;
    localparam int TARGET_WORDS = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PRINT_CAP    = 40;

    localparam logic [CNT_W-1:0] CNT_TOP = '1;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [2:0] OP_DASH = 3'd0;
    localparam logic [7:0] OP_CHARS [OP_N] = '{"-", "+", "=", "<", ">", "!"};
    localparam logic [7:0] MARK_CHARS [10] = '{"(", ")", "[", "]", "{", "}", ",", ":", "*", ";"};
    localparam kind_t MARK_KINDS [10] = '{KIND_LPAREN, KIND_RPAREN, KIND_LBRACK, KIND_RBRACK,
                                          KIND_LBRACE, KIND_RBRACE, KIND_COMMA, KIND_COLON,
                                          KIND_STAR, KIND_SEMI};

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } src_word_t;

    typedef enum logic [1:0] {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_LONG} sink_style_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] byte_value = CH_NUL;
    logic end_of_text = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic [KIND_W-1:0] token_kind;
    logic [OUT_W-1:0] token_line;
    logic [OUT_W-1:0] token_start;
    logic [OUT_W-1:0] token_length;
    logic run_last;

    src_word_t byte_feed [$];
    src_word_t next_word;
    token_t expected_tokens [$];
    token_t want_tok;

    logic [CNT_W-1:0] cur_line;
    logic [CNT_W-1:0] cur_pos;
    logic [CNT_W-1:0] tok_begin;
    logic [CNT_W-1:0] word_len;
    logic [1:0] scan_mode;
    logic [2:0] held_op;
    logic [KW_N-1:0] kw_alive;
    logic [4:0] word_flags;
    int step_tokens;

    int words_accepted = 0;
    int total_words = 0;
    int error_count = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int style_left = 64;
    sink_style_t sink_style = SINK_FREE;

    byte_stream_tokenizer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_value   (byte_value),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_line   (token_line),
        .token_start  (token_start),
        .token_length (token_length),
        .run_last     (run_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] x);
        return (x == CNT_TOP) ? x : x + 1'b1;
    endfunction

    function automatic logic is_gap(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alnum_ch(input logic [7:0] b);
        return is_num(b) || ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic int mark_slot(input logic [7:0] b);
        int slot;
        slot = -1;
        for (int i = 0; i < 10; i++)
            if (MARK_CHARS[i] == b)
                slot = i;
        return slot;
    endfunction

    function automatic int op_slot(input logic [7:0] b);
        int slot;
        slot = -1;
        for (int i = 0; i < OP_N; i++)
            if (OP_CHARS[i] == b)
                slot = i;
        return slot;
    endfunction

    function automatic void push_token(input kind_t kind, input logic [CNT_W-1:0] start,
                                       input logic [CNT_W-1:0] len);
        token_t t;
        t.kind   = kind;
        t.line   = cur_line[OUT_W-1:0];
        t.start  = start[OUT_W-1:0];
        t.length = len[OUT_W-1:0];
        t.last   = 1'b0;
        if (step_tokens < MAX_PER_WORD)
        begin
            expected_tokens.push_back(t);
            step_tokens++;
        end
    endfunction

    function automatic void grow_word(input logic [7:0] b);
        for (int k = 0; k < KW_N; k++)
            if (kw_alive[k] && (word_len >= KW_LEN[k] || KW_TEXT[k][word_len[2:0]] != b))
                kw_alive[k] = 1'b0;
        if (!is_num(b))
            word_flags[F_DIGITS] = 1'b0;
        else
            word_flags[F_HASDIG] = 1'b1;
        if (!is_alnum_ch(b))
            word_flags[F_ALNUM] = 1'b0;
        if (b == ".")
        begin
            if (word_flags[F_DOT])
                word_flags[F_FLOATOK] = 1'b0;
            word_flags[F_DOT] = 1'b1;
        end
        else if (!is_num(b))
            word_flags[F_FLOATOK] = 1'b0;
        word_len = bump(word_len);
    endfunction

    function automatic void finish_word();
        kind_t kind;
        logic hit;
        hit = 1'b0;
        if (word_flags[F_DIGITS])
            kind = KIND_INT;
        else if (word_flags[F_FLOATOK] && word_flags[F_HASDIG])
            kind = KIND_FLOAT;
        else if (word_flags[F_ALNUM])
            kind = KIND_IDENT;
        else
            kind = KIND_UNKNOWN;
        for (int k = 0; k < KW_N; k++)
            if (!hit && kw_alive[k] && word_len == KW_LEN[k])
            begin
                kind = KW_KIND[k];
                hit = 1'b1;
            end
        push_token(kind, tok_begin, word_len);
    endfunction

    function automatic void flush_pending();
        if (scan_mode == MODE_WORD)
            finish_word();
        else if (scan_mode == MODE_HELD)
            push_token(OP_SINGLE[held_op], tok_begin, CNT_W'(1));
        scan_mode = MODE_IDLE;
    endfunction

    function automatic void clear_scan();
        cur_line   = '0;
        cur_pos    = '0;
        tok_begin  = '0;
        word_len   = '0;
        scan_mode  = MODE_IDLE;
        held_op    = '0;
        kw_alive   = '0;
        word_flags = '0;
    endfunction

    function automatic void take_fresh(input logic [7:0] b, input logic [CNT_W-1:0] p);
        int mk;
        int ok;
        mk = mark_slot(b);
        ok = op_slot(b);
        if (is_gap(b))
        begin
            if (b == CH_LF)
                cur_line = bump(cur_line);
        end
        else if (mk >= 0)
            push_token(MARK_KINDS[mk], p, CNT_W'(1));
        else if (ok >= 0)
        begin
            held_op   = 3'(ok);
            tok_begin = p;
            scan_mode = MODE_HELD;
        end
        else
        begin
            tok_begin  = p;
            word_len   = '0;
            kw_alive   = '1;
            word_flags = '0;
            word_flags[F_DIGITS]  = 1'b1;
            word_flags[F_ALNUM]   = 1'b1;
            word_flags[F_FLOATOK] = 1'b1;
            scan_mode  = MODE_WORD;
            grow_word(b);
        end
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input logic last);
        logic [CNT_W-1:0] p;
        token_t t;
        p = cur_pos;
        step_tokens = 0;
        if (b == CH_NUL)
        begin
            flush_pending();
            clear_scan();
        end
        else
        begin
            if (scan_mode == MODE_HELD)
            begin
                scan_mode = MODE_IDLE;
                if (held_op == OP_DASH && b == ">")
                    push_token(KIND_ARROW, tok_begin, CNT_W'(2));
                else if (b == "=")
                    push_token(OP_EQUAL[held_op], tok_begin, CNT_W'(2));
                else
                begin
                    push_token(OP_SINGLE[held_op], tok_begin, CNT_W'(1));
                    take_fresh(b, p);
                end
            end
            else if (scan_mode == MODE_WORD)
            begin
                if (is_gap(b) || mark_slot(b) >= 0 || op_slot(b) >= 0)
                begin
                    finish_word();
                    scan_mode = MODE_IDLE;
                    take_fresh(b, p);
                end
                else
                    grow_word(b);
            end
            else
                take_fresh(b, p);
            cur_pos = bump(cur_pos);
            if (last)
            begin
                flush_pending();
                clear_scan();
            end
        end
        if (step_tokens > 0)
        begin
            t = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
        end
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic last);
        src_word_t w;
        w.value = b;
        w.last  = last;
        byte_feed.push_back(w);
    endtask

    task automatic put_text(input string s, input logic last_on_end);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], last_on_end && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    task automatic put_digits(input int n);
        repeat (n) put_byte(pick_char("0123456789"), 1'b0);
    endtask

    function automatic string vocab_word(input int n);
        string w;
        case (n)
            0:  w = "func";
            1:  w = "range";
            2:  w = "for";
            3:  w = "if";
            4:  w = "else";
            5:  w = "return";
            6:  w = "tensor";
            7:  w = "in";
            8:  w = "or";
            9:  w = "OR";
            10: w = "and";
            11: w = "fun";
            12: w = "funcs";
            13: w = "fo";
            14: w = "forx";
            15: w = "iff";
            16: w = "elsex";
            17: w = "retur";
            18: w = "tensors";
            19: w = "Or";
            20: w = "ands";
            default: w = "int";
        endcase
        return w;
    endfunction

    function automatic string op_text(input int n);
        string w;
        case (n)
            0:  w = "-";
            1:  w = "+";
            2:  w = "=";
            3:  w = "<";
            4:  w = ">";
            5:  w = "!";
            6:  w = "->";
            7:  w = "-=";
            8:  w = "+=";
            9:  w = "==";
            10: w = "<=";
            11: w = ">=";
            default: w = "!=";
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t %s: got %0h expected %0h", $time, what, got, want);
    endtask

    // Feed bytes in bursts; hold the word while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            byte_value  <= CH_NUL;
            end_of_text <= 1'b0;
            burst_left  <= 1;
            gap_left    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                tokenize_byte(byte_value, end_of_text);
                words_accepted++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (byte_feed.size() != 0)
                begin
                    next_word = byte_feed.pop_front();
                    in_valid    <= 1'b1;
                    byte_value  <= next_word.value;
                    end_of_text <= next_word.last;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (style_left == 0)
            begin
                sink_style <= sink_style_t'($urandom_range(0, 3));
                style_left <= $urandom_range(32, 256);
            end
            else
                style_left <= style_left - 1;
            case (sink_style)
                SINK_FREE:  out_stall <= 1'b0;
                SINK_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
                SINK_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
                default:    out_stall <= ((style_left % 16) < 11);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch("token with none pending, kind", 32'(token_kind), 32'd0);
            else
            begin
                want_tok = expected_tokens.pop_front();
                if (token_kind !== want_tok.kind)
                    report_mismatch("token_kind", 32'(token_kind), 32'(want_tok.kind));
                if (token_line !== want_tok.line)
                    report_mismatch("token_line", 32'(token_line), 32'(want_tok.line));
                if (token_start !== want_tok.start)
                    report_mismatch("token_start", 32'(token_start), 32'(want_tok.start));
                if (token_length !== want_tok.length)
                    report_mismatch("token_length", 32'(token_length),
                                    32'(want_tok.length));
                if (run_last !== want_tok.last)
                    report_mismatch("run_last", 32'(run_last), 32'(want_tok.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        src_word_t tail;
        int len;
        clear_scan();

        put_text("func f(x)->1.2{a+=b!=c}\n", 1'b0);
        put_text("<", 1'b1);
        put_text("a", 1'b0);
        put_byte(CH_NUL, 1'b0);

        while (byte_feed.size() < TARGET_WORDS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 12))
                    put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 9:
                            put_text(vocab_word($urandom_range(0, 21)), 1'b0);
                        2:
                        begin
                            len = $urandom_range(0, 7);
                            put_byte(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"),
                                     1'b0);
                            repeat (len)
                                put_byte(pick_char({"abcdefghijklmnopqrstuvwxyz",
                                                    "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789"}),
                                         1'b0);
                        end
                        3:
                            put_digits($urandom_range(1, 7));
                        4:
                        begin
                            case ($urandom_range(0, 4))
                                0:
                                begin
                                    put_digits($urandom_range(1, 4));
                                    put_byte(".", 1'b0);
                                    put_digits($urandom_range(1, 4));
                                end
                                1:
                                begin
                                    put_byte(".", 1'b0);
                                    put_digits($urandom_range(1, 3));
                                end
                                2:
                                begin
                                    put_digits($urandom_range(1, 3));
                                    put_byte(".", 1'b0);
                                end
                                3:
                                begin
                                    put_digits($urandom_range(1, 2));
                                    put_byte(".", 1'b0);
                                    put_digits($urandom_range(0, 2));
                                    put_byte(".", 1'b0);
                                    put_digits($urandom_range(1, 2));
                                end
                                default:
                                begin
                                    if ($urandom_range(0, 1) == 0)
                                        put_text(".", 1'b0);
                                    else
                                        put_text("..", 1'b0);
                                end
                            endcase
                        end
                        5, 6:
                            put_text(op_text($urandom_range(0, 12)), 1'b0);
                        7:
                            put_byte(MARK_CHARS[$urandom_range(0, 9)], 1'b0);
                        default:
                        begin
                            repeat ($urandom_range(1, 6))
                            begin
                                case ($urandom_range(0, 2))
                                    0: put_byte(pick_char("abcXYZ019"), 1'b0);
                                    1: put_byte(pick_char("_#$@.?~`'\"\\^&|%"), 1'b0);
                                    default: put_byte(8'($urandom_range(128, 255)), 1'b0);
                                endcase
                            end
                        end
                    endcase
                    case ($urandom_range(0, 7))
                        0: ;
                        1, 2: put_byte(CH_SP, 1'b0);
                        3: put_byte(CH_TAB, 1'b0);
                        4: put_byte(CH_CR, 1'b0);
                        5: put_byte(CH_LF, 1'b0);
                        6:
                        begin
                            put_byte(CH_CR, 1'b0);
                            put_byte(CH_LF, 1'b0);
                        end
                        default: repeat ($urandom_range(2, 4)) put_byte(CH_SP, 1'b0);
                    endcase
                end
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        tail = byte_feed.pop_back();
                        tail.last = 1'b1;
                        byte_feed.push_back(tail);
                    end
                    2: put_byte(CH_NUL, 1'b0);
                    default: ;
                endcase
            end
        end
        total_words = byte_feed.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (words_accepted != total_words)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
